>>> hw/rtl/bjh_pkg.sv
// Shared constants and helpers for the B-spline joint histogram.
package bjh_pkg;

  localparam int unsigned MaxChannelsDef = 64;
  localparam int unsigned PixelBitsDef   = 16;
  localparam int unsigned FracBitsDef    = 16;

  localparam int unsigned BinW   = 40;
  localparam int unsigned ScaleW = 30;
  localparam int unsigned InPixW = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFixedMin   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFixedScale = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMovingMin  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMovingScale = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgChanCount  = 3'd4;

  // Request codes
  localparam logic [2:0] ReqAccum     = 3'd0;
  localparam logic [2:0] ReqReadJoint = 3'd1;
  localparam logic [2:0] ReqReadFixed = 3'd2;
  localparam logic [2:0] ReqReadMove  = 3'd3;
  localparam logic [2:0] ReqClear     = 3'd4;

  localparam logic [BinW-1:0] BinMax = '1;

  // Saturating add of a bin and an increment
  function automatic logic [BinW-1:0] sat_add(input logic [BinW-1:0] a,
                                              input logic [BinW-1:0] b);
    logic [BinW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BinW] ? BinMax : s[BinW-1:0];
  endfunction

endpackage

>>> hw/rtl/bspline_joint_histogram.sv
// Top level: request sequencer around joint and marginal histogram memories.
//  Channel | Signals                                   | Direction
//  cfg     | cfg_valid_i/cfg_ready_o, index, data       | in
//  req     | req_valid_i/req_ready_o, six request fields| in
//  rsp     | rsp_valid_o/rsp_ready_i, bin_value, error  | out
// Accumulate: the coders run first (StEnc), then 9 read-modify-write steps, one a cycle
// through the joint RAM port (marginals ride the first three steps).
// Reads: StRead, then StReadOut to a registered result. Clear sweeps MaxChannels^2 entries.
// After reset a clearing pass over MaxChannels^2 entries runs before any request.
// A result waiting in the output register holds off new requests until taken.
module bspline_joint_histogram import bjh_pkg::*; #(
  parameter int unsigned MaxChannels = MaxChannelsDef,
  parameter int unsigned PixelBits   = PixelBitsDef,
  parameter int unsigned FracBits    = FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic [2:0]            req_type_i,
  input  logic [InPixW-1:0]     fixed_pixel_i,
  input  logic [InPixW-1:0]     moving_pixel_i,
  input  logic                  pixel_valid_i,
  input  logic [5:0]            bin_row_i,
  input  logic [5:0]            bin_col_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output logic [BinW-1:0]       bin_value_o,
  output logic                  index_error_o
);

  localparam int unsigned ChW = $clog2(MaxChannels);
  localparam int unsigned CW  = $clog2(MaxChannels+1);
  localparam int unsigned JW  = 2*ChW;
  localparam int unsigned JDepth = MaxChannels*MaxChannels;

  typedef enum logic [2:0] {
    StClear, StIdle, StEnc, StAcc, StRead, StReadOut
  } state_e;

  state_e state_q;
  logic [InPixW-1:0] fmin_q, mmin_q;
  logic [ScaleW-1:0] fscale_q, mscale_q;
  logic [CountW-1:0] count_q;
  logic [CW-1:0] chans;
  logic [JW:0] sweep_q;
  logic [2:0] enc_cnt_q;
  logic [3:0] step_q;
  logic [2:0] rtype_q;
  logic rerr_q;
  logic [InPixW-1:0] fpix_q, mpix_q;
  logic [5:0] row_q, col_q;

  // Clamp channel count to [3, MaxChannels]
  always_comb begin
    if (count_q < CountW'(3))                         chans = CW'(3);
    else if (32'(count_q) > MaxChannels)              chans = CW'(MaxChannels);
    else                                              chans = CW'(count_q);
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmin_q <= '0; fscale_q <= '0; mmin_q <= '0; mscale_q <= '0;
      count_q <= CountW'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFixedMin:    fmin_q   <= cfg_data_i[InPixW-1:0];
        CfgFixedScale:  fscale_q <= cfg_data_i[ScaleW-1:0];
        CfgMovingMin:   mmin_q   <= cfg_data_i[InPixW-1:0];
        CfgMovingScale: mscale_q <= cfg_data_i[ScaleW-1:0];
        CfgChanCount:   count_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Channel coders
  logic [ChW-1:0] ff, fm;
  logic [FracBits:0] wf0, wf1, wf2, wm0, wm1, wm2;
  logic enc_start;
  assign enc_start = (state_q == StEnc) && (enc_cnt_q == 3'd0);

  bjh_encoder #(.MaxChannels(MaxChannels), .PixelBits(PixelBits), .FracBits(FracBits))
    u_enc_f (.clk_i, .start_i(enc_start), .pixel_i(fpix_q), .min_i(fmin_q),
             .scale_i(fscale_q), .chans_i(chans), .first_o(ff),
             .w0_o(wf0), .w1_o(wf1), .w2_o(wf2));
  bjh_encoder #(.MaxChannels(MaxChannels), .PixelBits(PixelBits), .FracBits(FracBits))
    u_enc_m (.clk_i, .start_i(enc_start), .pixel_i(mpix_q), .min_i(mmin_q),
             .scale_i(mscale_q), .chans_i(chans), .first_o(fm),
             .w0_o(wm0), .w1_o(wm1), .w2_o(wm2));

  // Accumulate step i,j from step counter; stage A issues reads
  logic [1:0] si, sj;
  logic [FracBits:0] wfi, wmj;
  logic [ChW-1:0] rowi, colj;
  always_comb begin
    unique case (step_q)
      4'd0, 4'd1, 4'd2: si = 2'd0;
      4'd3, 4'd4, 4'd5: si = 2'd1;
      default:          si = 2'd2;
    endcase
    unique case (step_q)
      4'd0, 4'd3, 4'd6: sj = 2'd0;
      4'd1, 4'd4, 4'd7: sj = 2'd1;
      default:          sj = 2'd2;
    endcase
    unique case (si)
      2'd0: wfi = wf0; 2'd1: wfi = wf1; default: wfi = wf2;
    endcase
    unique case (sj)
      2'd0: wmj = wm0; 2'd1: wmj = wm1; default: wmj = wm2;
    endcase
  end
  assign rowi = ff + ChW'(si);
  assign colj = fm + ChW'(sj);

  // Stage A: RAM read and increment product; stage B: add and write back
  logic acc_go;
  logic [JW-1:0] jaddr_a;
  logic [ChW-1:0] faddr_a, maddr_a;
  logic [2*FracBits+1:0] prod_a;
  assign acc_go  = (state_q == StAcc) && (step_q < 4'd9);
  assign jaddr_a = (state_q == StAcc) ? {rowi, colj}
                                      : {row_q[ChW-1:0], col_q[ChW-1:0]};
  assign faddr_a = (state_q == StAcc) ? ff + ChW'(sj) : row_q[ChW-1:0];
  assign maddr_a = (state_q == StAcc) ? fm + ChW'(sj) : col_q[ChW-1:0];
  assign prod_a  = (2*FracBits+2)'(wfi) * (2*FracBits+2)'(wmj);

  logic wb_q, mwb_q;
  logic [JW-1:0] jaddr_q;
  logic [ChW-1:0] faddr_q, maddr_q;
  logic [BinW-1:0] jinc_q, finc_q, minc_q;
  logic [BinW-1:0] jrd, frd, mrd;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= 1'b0; mwb_q <= 1'b0;
    end else begin
      wb_q  <= acc_go;
      mwb_q <= acc_go && (step_q < 4'd3);
    end
  end
  always_ff @(posedge clk_i) begin
    jaddr_q <= jaddr_a;
    faddr_q <= faddr_a;
    maddr_q <= maddr_a;
    jinc_q  <= BinW'(prod_a >> FracBits);
    finc_q  <= BinW'(unsigned'(sj == 2'd0 ? wf0 : (sj == 2'd1 ? wf1 : wf2)));
    minc_q  <= BinW'(unsigned'(wmj));
  end

  // Memories; clear sweep writes zero
  logic clr;
  logic jwe, fwe, mwe;
  logic [JW-1:0] jwaddr;
  logic [ChW-1:0] fwaddr, mwaddr;
  logic [BinW-1:0] jwdata, fwdata, mwdata;
  assign clr    = (state_q == StClear);
  assign jwe    = clr || wb_q;
  assign fwe    = (clr && (sweep_q[JW-1:ChW] == '0)) || mwb_q;
  assign mwe    = fwe;
  assign jwaddr = clr ? sweep_q[JW-1:0] : jaddr_q;
  assign fwaddr = clr ? sweep_q[ChW-1:0] : faddr_q;
  assign mwaddr = clr ? sweep_q[ChW-1:0] : maddr_q;
  assign jwdata = clr ? '0 : sat_add(jrd, jinc_q);
  assign fwdata = clr ? '0 : sat_add(frd, finc_q);
  assign mwdata = clr ? '0 : sat_add(mrd, minc_q);

  bjh_ram #(.Width(BinW), .Depth(JDepth)) u_joint (
    .clk_i, .we_i(jwe), .waddr_i(jwaddr), .wdata_i(jwdata),
    .raddr_i(jaddr_a), .rdata_o(jrd));
  bjh_ram #(.Width(BinW), .Depth(MaxChannels)) u_fixed (
    .clk_i, .we_i(fwe), .waddr_i(fwaddr), .wdata_i(fwdata),
    .raddr_i(faddr_a), .rdata_o(frd));
  bjh_ram #(.Width(BinW), .Depth(MaxChannels)) u_moving (
    .clk_i, .we_i(mwe), .waddr_i(mwaddr), .wdata_i(mwdata),
    .raddr_i(maddr_a), .rdata_o(mrd));

  // Request sequencer and result register
  logic req_acc;
  assign req_ready_o = (state_q == StIdle) && !rsp_valid_o;
  assign req_acc     = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; sweep_q <= '0; enc_cnt_q <= '0; step_q <= '0;
      rsp_valid_o <= 1'b0; bin_value_o <= '0; index_error_o <= 1'b0;
      rtype_q <= ReqAccum; rerr_q <= 1'b0;
      fpix_q <= '0; mpix_q <= '0; row_q <= '0; col_q <= '0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) rsp_valid_o <= 1'b0;
      unique case (state_q)
        StClear: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q[JW-1:0] == JW'(JDepth-1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (req_acc) begin
            fpix_q <= fixed_pixel_i; mpix_q <= moving_pixel_i;
            row_q <= bin_row_i; col_q <= bin_col_i;
            rtype_q <= req_type_i;
            unique case (req_type_i)
              ReqAccum: begin
                if (pixel_valid_i) begin
                  state_q <= StEnc; enc_cnt_q <= '0;
                end
              end
              ReqClear: begin
                state_q <= StClear; sweep_q <= '0;
              end
              ReqReadJoint: begin
                state_q <= StRead;
                rerr_q  <= (7'(bin_row_i) >= 7'(chans)) || (7'(bin_col_i) >= 7'(chans));
              end
              ReqReadFixed: begin
                state_q <= StRead; rerr_q <= 7'(bin_row_i) >= 7'(chans);
              end
              ReqReadMove: begin
                state_q <= StRead; rerr_q <= 7'(bin_col_i) >= 7'(chans);
              end
              default: ;
            endcase
          end
        end
        StEnc: begin
          enc_cnt_q <= enc_cnt_q + 3'd1;
          if (enc_cnt_q == 3'd4) begin
            state_q <= StAcc; step_q <= '0;
          end
        end
        StAcc: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd9) state_q <= StIdle;
        end
        StRead: state_q <= StReadOut;
        StReadOut: begin
          state_q       <= StIdle;
          rsp_valid_o   <= 1'b1;
          index_error_o <= rerr_q;
          unique case (rtype_q)
            ReqReadJoint: bin_value_o <= rerr_q ? '0 : jrd;
            ReqReadFixed: bin_value_o <= rerr_q ? '0 : frd;
            default:      bin_value_o <= rerr_q ? '0 : mrd;
          endcase
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> hw/rtl/bjh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bjh_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/bjh_encoder.sv
// Channel coder: pixel to first channel and three B-spline weights, pipelined.
module bjh_encoder import bjh_pkg::*; #(
  parameter int unsigned MaxChannels = MaxChannelsDef,
  parameter int unsigned PixelBits   = PixelBitsDef,
  parameter int unsigned FracBits    = FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           start_i,
  input  logic [InPixW-1:0]              pixel_i,
  input  logic [InPixW-1:0]              min_i,
  input  logic [ScaleW-1:0]              scale_i,
  input  logic [$clog2(MaxChannels+1)-1:0] chans_i,
  output logic [$clog2(MaxChannels)-1:0] first_o,
  output logic [FracBits:0]              w0_o,
  output logic [FracBits:0]              w1_o,
  output logic [FracBits:0]              w2_o
);

  localparam int unsigned ChW  = $clog2(MaxChannels);
  localparam int unsigned CW   = $clog2(MaxChannels+1);
  localparam int unsigned ProdW = PixelBits + ScaleW;
  localparam int unsigned Shr  = 24 - FracBits;
  localparam logic [FracBits:0] One = {1'b1, {FracBits{1'b0}}};

  logic [PixelBits-1:0] p, lo, d;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [ProdW-1:0] pos;
  logic [ProdW-FracBits-1:0] ch;
  logic [CW-1:0] chans_q;
  logic [ChW-1:0] first_d;
  logic [FracBits:0] t_d, u;
  logic [2*FracBits+1:0] uu_d, tt_d, uu_q, tt_q;
  logic [FracBits:0] w0, w2;

  // Stage 1: difference times scale
  assign p  = pixel_i[PixelBits-1:0];
  assign lo = min_i[PixelBits-1:0];
  assign d  = (p > lo) ? p - lo : '0;
  assign prod_d = ProdW'(d) * ProdW'(scale_i);

  // Stage 2: split, top-end clamp, squares
  assign pos = prod_q >> Shr;
  assign ch  = pos[ProdW-1:FracBits];
  always_comb begin
    if (ch >= (ProdW-FracBits)'(chans_q - CW'(2))) begin
      first_d = ChW'(chans_q - CW'(3));
      t_d     = One;
    end else begin
      first_d = ch[ChW-1:0];
      t_d     = {1'b0, pos[FracBits-1:0]};
    end
  end
  assign u    = One - t_d;
  assign uu_d = (2*FracBits+2)'(u) * (2*FracBits+2)'(u);
  assign tt_d = (2*FracBits+2)'(t_d) * (2*FracBits+2)'(t_d);

  // Stage 3: weights
  assign w0 = (FracBits+1)'(uu_q >> (FracBits+1));
  assign w2 = (FracBits+1)'(tt_q >> (FracBits+1));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q  <= prod_d;
      chans_q <= chans_i;
    end
    uu_q    <= uu_d;
    tt_q    <= tt_d;
    first_o <= first_d;
    w0_o    <= w0;
    w2_o    <= w2;
    w1_o    <= One - w0 - w2;
  end

endmodule

>>> hw/rtl/bjh_checker.sv
// Port-level assertions for the joint histogram, bound to the top level.
module bjh_checker import bjh_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input logic [2:0] req_type_i,
  input logic pixel_valid_i,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input logic [BinW-1:0] bin_value_o,
  input logic index_error_o
);

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(bin_value_o))
    else $error("result changed under stall");

  // An index error carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && index_error_o |-> bin_value_o == '0)
    else $error("error result with nonzero value");

  // No new request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request taken while result pending");

  // A request that does work is not followed by ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o &&
      ((req_type_i == ReqAccum && pixel_valid_i) || req_type_i == ReqReadJoint ||
       req_type_i == ReqReadFixed || req_type_i == ReqReadMove ||
       req_type_i == ReqClear) |=> !req_ready_o)
    else $error("ready right after a request");

endmodule

bind bspline_joint_histogram bjh_checker u_bjh_checker (.*);
